// ===== hw/rtl/msf_pkg.sv =====
`default_nettype none

package msf_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int SIZE_BITS      = 20;
  localparam int FAR_BITS       = SIZE_BITS + 1;
  localparam int RAD_BITS       = 2 * FAR_BITS + 2;
  localparam int DIST_BITS      = FAR_BITS + 1;
  localparam int SQ_REM_BITS    = DIST_BITS + 2;
  localparam int SQ_STAGES      = DIST_BITS / 2;
  localparam int Q_BITS         = 24;
  localparam int DIV_STAGES     = Q_BITS / 2;
  localparam int V_BITS         = 48;
  localparam int PIPE_LAT       = 35;

  localparam logic [SIZE_BITS-1:0] BASE_RESET = 20'd6554;
  localparam logic [Q_BITS-1:0]    T_MIN      = 24'h800000;

  localparam logic [2:0] REG_BASE   = 3'd0;
  localparam logic [2:0] REG_NCTR   = 3'd1;
  localparam logic [2:0] REG_NSHAPE = 3'd2;
  localparam logic [2:0] REG_HCTR   = 3'd3;
  localparam logic [2:0] REG_HSHAPE = 3'd4;

  typedef struct packed {
    logic [SIZE_BITS-1:0] band;
    logic [SIZE_BITS-1:0] near;
    logic [SIZE_BITS-1:0] radius;
  } shape_t;

  typedef struct packed {
    logic                     prop;
    logic signed [V_BITS-1:0] v;
  } lane_out_t;

  typedef struct packed {
    logic [SQ_REM_BITS-1:0] rem;
    logic [DIST_BITS-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] rem;
    logic                 qb;
  } dv_t;

  // One digit of a bit-by-bit square root.
  function automatic sq_t sqrt_step(input logic [SQ_REM_BITS-1:0] rem,
                                    input logic [DIST_BITS-1:0] root,
                                    input logic [1:0] bits);
    logic [SQ_REM_BITS+1:0] r2;
    logic [SQ_REM_BITS+1:0] trial;
    sq_t res;
    r2    = {rem, bits};
    trial = {2'b00, root, 2'b01};
    if (r2 >= trial) begin
      res.rem  = SQ_REM_BITS'(r2 - trial);
      res.root = {root[DIST_BITS-2:0], 1'b1};
    end else begin
      res.rem  = r2[SQ_REM_BITS-1:0];
      res.root = {root[DIST_BITS-2:0], 1'b0};
    end
    return res;
  endfunction

  // One quotient bit of a restoring division.
  function automatic dv_t div_step(input logic [SIZE_BITS-1:0] rem, input logic nb,
                                   input logic [SIZE_BITS-1:0] den);
    logic [SIZE_BITS:0] r2;
    dv_t res;
    r2 = {rem, nb};
    if (r2 >= {1'b0, den}) begin
      res.rem = SIZE_BITS'(r2 - {1'b0, den});
      res.qb  = 1'b1;
    end else begin
      res.rem = r2[SIZE_BITS-1:0];
      res.qb  = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/msf_circle.sv =====
`default_nettype none

module msf_circle #(
  parameter int COORD_BITS = msf_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic signed [COORD_BITS-1:0]     px,
  input  logic signed [COORD_BITS-1:0]     py,
  input  logic [2*COORD_BITS-1:0]          center,
  input  msf_pkg::shape_t                  shape,
  input  logic [msf_pkg::SIZE_BITS-1:0]    base,
  output msf_pkg::lane_out_t               lane_out
);
  import msf_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int AW = (DW > FAR_BITS + 1) ? DW : FAR_BITS + 1;

  // distance offsets and far test
  logic signed [COORD_BITS-1:0] cx, cy;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0] ax_full, ay_full;
  logic [AW-1:0] ax_ext, ay_ext;
  logic far;

  logic                vld1_r, skip1_r;
  logic [FAR_BITS-1:0] ax1_r, ay1_r;

  assign cx      = center[COORD_BITS-1:0];
  assign cy      = center[2*COORD_BITS-1:COORD_BITS];
  assign dx      = {px[COORD_BITS-1], px} - {cx[COORD_BITS-1], cx};
  assign dy      = {py[COORD_BITS-1], py} - {cy[COORD_BITS-1], cy};
  assign ax_full = dx[DW-1] ? (~dx + 1'b1) : dx;
  assign ay_full = dy[DW-1] ? (~dy + 1'b1) : dy;
  assign ax_ext  = AW'(ax_full);
  assign ay_ext  = AW'(ay_full);
  assign far     = (ax_ext[AW-1:FAR_BITS] != '0) || (ay_ext[AW-1:FAR_BITS] != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    ax1_r   <= ax_ext[FAR_BITS-1:0];
    ay1_r   <= ay_ext[FAR_BITS-1:0];
    skip1_r <= far || (shape.band == '0);
  end

  // squares, then their sum
  logic                  vld2_r, skip2_r, vld3_r, skip3_r;
  logic [2*FAR_BITS-1:0] sqx2_r, sqy2_r;
  logic [RAD_BITS-1:0]   rad3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    sqx2_r  <= ax1_r * ax1_r;
    sqy2_r  <= ay1_r * ay1_r;
    skip2_r <= skip1_r;
    rad3_r  <= RAD_BITS'(sqx2_r) + RAD_BITS'(sqy2_r);
    skip3_r <= skip2_r;
  end

  // square root, two digits a stage
  logic [RAD_BITS-1:0]    sq_rad_r  [SQ_STAGES];
  logic [SQ_REM_BITS-1:0] sq_rem_r  [SQ_STAGES];
  logic [DIST_BITS-1:0]   sq_root_r [SQ_STAGES];
  logic                   sq_vld_r  [SQ_STAGES];
  logic                   sq_skip_r [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [RAD_BITS-1:0]    rad_in;
    logic [SQ_REM_BITS-1:0] rem_in;
    logic [DIST_BITS-1:0]   root_in;
    logic                   vld_in, skip_in;
    sq_t                    s1, s2;

    if (k == 0) begin : g_first
      assign rad_in  = rad3_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = vld3_r;
      assign skip_in = skip3_r;
    end else begin : g_next
      assign rad_in  = sq_rad_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
      assign vld_in  = sq_vld_r[k-1];
      assign skip_in = sq_skip_r[k-1];
    end

    assign s1 = sqrt_step(rem_in, root_in, rad_in[RAD_BITS-1 -: 2]);
    assign s2 = sqrt_step(s1.rem, s1.root, rad_in[RAD_BITS-3 -: 2]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else begin
        sq_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      sq_rad_r[k]  <= {rad_in[RAD_BITS-5:0], 4'b0000};
      sq_rem_r[k]  <= s2.rem;
      sq_root_r[k] <= s2.root;
      sq_skip_r[k] <= skip_in;
    end
  end

  // signed distance to the rim, band test, magnitude for the divider
  logic signed [Q_BITS-1:0] d_val;
  logic [Q_BITS-1:0]        d_mag;
  logic                     outside;
  logic                     vldd_r, skipd_r, negd_r, clampd_r;
  logic [SIZE_BITS-1:0]     magd_r;

  assign d_val   = $signed({2'b00, sq_root_r[SQ_STAGES-1]}) - $signed({4'h0, shape.radius});
  assign outside = d_val >= $signed({4'h0, shape.band});
  assign d_mag   = d_val[Q_BITS-1] ? (~d_val + 1'b1) : d_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldd_r <= 1'b0;
    end else begin
      vldd_r <= sq_vld_r[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    skipd_r  <= sq_skip_r[SQ_STAGES-1] || outside;
    negd_r   <= d_val[Q_BITS-1];
    // t would fall below -128.0
    clampd_r <= d_val[Q_BITS-1] && ({3'b000, d_mag} > {shape.band, 7'b0});
    magd_r   <= d_mag[SIZE_BITS-1:0];
  end

  // t = d * 2^16 / band, two quotient bits a stage
  logic [SIZE_BITS-1:0] dv_rem_r  [DIV_STAGES];
  logic [Q_BITS-1:0]    dv_strm_r [DIV_STAGES];
  logic [Q_BITS-1:0]    dv_q_r    [DIV_STAGES];
  logic                 dv_vld_r  [DIV_STAGES];
  logic                 dv_skip_r [DIV_STAGES];
  logic                 dv_neg_r  [DIV_STAGES];
  logic                 dv_clamp_r[DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [SIZE_BITS-1:0] rem_in;
    logic [Q_BITS-1:0]    strm_in, q_in;
    logic                 vld_in, skip_in, neg_in, clamp_in;
    dv_t                  s1, s2;

    if (k == 0) begin : g_first
      assign rem_in   = {8'h00, magd_r[SIZE_BITS-1:8]};
      assign strm_in  = {magd_r[7:0], 16'h0000};
      assign q_in     = '0;
      assign vld_in   = vldd_r;
      assign skip_in  = skipd_r;
      assign neg_in   = negd_r;
      assign clamp_in = clampd_r;
    end else begin : g_next
      assign rem_in   = dv_rem_r[k-1];
      assign strm_in  = dv_strm_r[k-1];
      assign q_in     = dv_q_r[k-1];
      assign vld_in   = dv_vld_r[k-1];
      assign skip_in  = dv_skip_r[k-1];
      assign neg_in   = dv_neg_r[k-1];
      assign clamp_in = dv_clamp_r[k-1];
    end

    assign s1 = div_step(rem_in, strm_in[Q_BITS-1], shape.band);
    assign s2 = div_step(s1.rem, strm_in[Q_BITS-2], shape.band);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else begin
        dv_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      dv_rem_r[k]   <= s2.rem;
      dv_strm_r[k]  <= {strm_in[Q_BITS-3:0], 2'b00};
      dv_q_r[k]     <= {q_in[Q_BITS-3:0], s1.qb, s2.qb};
      dv_skip_r[k]  <= skip_in;
      dv_neg_r[k]   <= neg_in;
      dv_clamp_r[k] <= clamp_in;
    end
  end

  // floor of the signed quotient, clamped at -128.0
  logic [Q_BITS:0]          q_up;
  logic [Q_BITS-1:0]        t_nxt;
  logic                     vldt_r, skipt_r;
  logic signed [Q_BITS-1:0] t_r;

  assign q_up = {1'b0, dv_q_r[DIV_STAGES-1]} + (Q_BITS+1)'(dv_rem_r[DIV_STAGES-1] != '0);

  always_comb begin
    if (!dv_neg_r[DIV_STAGES-1]) begin
      t_nxt = dv_q_r[DIV_STAGES-1];
    end else if (dv_clamp_r[DIV_STAGES-1]) begin
      t_nxt = T_MIN;
    end else begin
      t_nxt = Q_BITS'(~q_up + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldt_r <= 1'b0;
    end else begin
      vldt_r <= dv_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    skipt_r <= dv_skip_r[DIV_STAGES-1];
  end

  // t^2, t^3, cubic, scale
  logic signed [2*Q_BITS-1:0] tt;
  logic signed [55:0]         t2t;
  logic signed [41:0]         p_nxt;
  logic signed [SIZE_BITS:0]  diff;
  logic signed [42:0]         pl_nxt;
  logic signed [41:0]         ph_nxt;

  logic                     vldm1_r, skipm1_r, vldm2_r, skipm2_r;
  logic                     vldp_r, skipp_r, vldm3_r, skipm3_r;
  logic [30:0]              t2m1_r, t2m2_r;
  logic signed [Q_BITS-1:0] tm1_r;
  logic signed [39:0]       t3m2_r;
  logic signed [41:0]       p_r;
  logic signed [42:0]       pl_r;
  logic signed [41:0]       ph_r;

  assign tt     = t_r * t_r;
  assign t2t    = $signed({1'b0, t2m1_r}) * tm1_r;
  assign p_nxt  = $signed({11'b0, t2m2_r}) + $signed({10'b0, t2m2_r, 1'b0})
                - $signed({t3m2_r[39], t3m2_r, 1'b0});
  assign diff   = $signed({1'b0, base}) - $signed({1'b0, shape.near});
  assign pl_nxt = diff * $signed({1'b0, p_r[20:0]});
  assign ph_nxt = diff * $signed(p_r[41:21]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldm1_r <= 1'b0;
      vldm2_r <= 1'b0;
      vldp_r  <= 1'b0;
      vldm3_r <= 1'b0;
    end else begin
      vldm1_r <= vldt_r;
      vldm2_r <= vldm1_r;
      vldp_r  <= vldm2_r;
      vldm3_r <= vldp_r;
    end
  end

  always_ff @(posedge clk) begin
    t2m1_r   <= tt[46:16];
    tm1_r    <= t_r;
    skipm1_r <= skipt_r;
    t2m2_r   <= t2m1_r;
    t3m2_r   <= t2t[55:16];
    skipm2_r <= skipm1_r;
    p_r      <= p_nxt;
    skipp_r  <= skipm2_r;
    pl_r     <= pl_nxt;
    ph_r     <= ph_nxt;
    skipm3_r <= skipp_r;
  end

  // join the partial products, drop the fraction, add near
  logic signed [63:0] prod;
  lane_out_t          lane_out_r;

  assign prod = $signed({ph_r[41], ph_r, 21'b0}) + $signed({{21{pl_r[42]}}, pl_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_out_r.prop <= 1'b0;
    end else begin
      lane_out_r.prop <= vldm3_r && !skipm3_r;
    end
  end

  always_ff @(posedge clk) begin
    lane_out_r.v <= $signed({28'b0, shape.near}) + $signed(prod[63:16]);
  end

  assign lane_out = lane_out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mesh_size_field_two_circles.sv =====
// Mesh element size at a query point, refined near a notch circle and a hole
// circle with a smoothstep blend, Q8.16 coordinates in, Q4.16 size out,
// saturated. One point is taken on every clock (busy stays low) and its size
// is shown with out_valid for a single cycle; there is no result backpressure.
// The pipeline runs through the input register, offset and far test, squares,
// their sum, the square-root pipeline (11 stages, two root bits each), the
// band test, the divider pipeline for t (12 stages, two quotient bits each),
// the rounding of t, t^2, t^3, the cubic, the scale, the add of the near size
// and the output register. Registers on the 64-bit APB port sit at byte
// address 8*i; write them only while no point is in flight.
`default_nettype none

module mesh_size_field_two_circles #(
  parameter int COORD_BITS = msf_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_BITS-1:0]         in_point_x,
  input  logic signed [COORD_BITS-1:0]         in_point_y,
  output logic                                 out_valid,
  output logic [msf_pkg::SIZE_BITS-1:0]        out_mesh_size,
  output logic                                 out_size_saturated,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [5:0]                           paddr,
  input  logic [63:0]                          pwdata,
  output logic [63:0]                          prdata,
  output logic                                 pready
);
  import msf_pkg::*;

  logic [SIZE_BITS-1:0]    base_r;
  logic [2*COORD_BITS-1:0] nctr_r, hctr_r;
  shape_t                  nshape_r, hshape_r;
  logic [2:0]              reg_idx;
  logic                    wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_RESET;
      nctr_r   <= '0;
      nshape_r <= '0;
      hctr_r   <= '0;
      hshape_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BASE:   base_r   <= pwdata[SIZE_BITS-1:0];
        REG_NCTR:   nctr_r   <= pwdata[2*COORD_BITS-1:0];
        REG_NSHAPE: nshape_r <= pwdata[3*SIZE_BITS-1:0];
        REG_HCTR:   hctr_r   <= pwdata[2*COORD_BITS-1:0];
        REG_HSHAPE: hshape_r <= pwdata[3*SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE:   prdata = 64'(base_r);
      REG_NCTR:   prdata = 64'(nctr_r);
      REG_NSHAPE: prdata = 64'(nshape_r);
      REG_HCTR:   prdata = 64'(hctr_r);
      REG_HSHAPE: prdata = 64'(hshape_r);
      default:    prdata = '0;
    endcase
  end

  // input register
  logic                         in_vld_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= in_point_x;
    py_r <= in_point_y;
  end

  lane_out_t notch_out, hole_out;

  msf_circle #(.COORD_BITS(COORD_BITS)) u_notch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .px       (px_r),
    .py       (py_r),
    .center   (nctr_r),
    .shape    (nshape_r),
    .base     (base_r),
    .lane_out (notch_out)
  );

  msf_circle #(.COORD_BITS(COORD_BITS)) u_hole (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld_r),
    .px       (px_r),
    .py       (py_r),
    .center   (hctr_r),
    .shape    (hshape_r),
    .base     (base_r),
    .lane_out (hole_out)
  );

  // valid bits of both lanes run in lockstep with the input register
  logic                     vld_pipe_r [PIPE_LAT-2];
  logic signed [V_BITS-1:0] size_sel;
  logic [SIZE_BITS-1:0]     size_nxt;
  logic                     sat_nxt;
  logic                     out_valid_r, out_sat_r;
  logic [SIZE_BITS-1:0]     out_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT - 2; i++) begin
        vld_pipe_r[i] <= 1'b0;
      end
    end else begin
      vld_pipe_r[0] <= in_vld_r;
      for (int i = 1; i < PIPE_LAT - 2; i++) begin
        vld_pipe_r[i] <= vld_pipe_r[i-1];
      end
    end
  end

  always_comb begin
    size_sel = $signed({{(V_BITS-SIZE_BITS){1'b0}}, base_r});
    if (notch_out.prop) begin
      size_sel = notch_out.v;
    end
    if (hole_out.prop && (hole_out.v < size_sel)) begin
      size_sel = hole_out.v;
    end
    if (size_sel[V_BITS-1]) begin
      size_nxt = '0;
      sat_nxt  = 1'b1;
    end else if (size_sel[V_BITS-2:SIZE_BITS] != '0) begin
      size_nxt = '1;
      sat_nxt  = 1'b1;
    end else begin
      size_nxt = size_sel[SIZE_BITS-1:0];
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_pipe_r[PIPE_LAT-3];
    end
  end

  always_ff @(posedge clk) begin
    out_size_r <= size_nxt;
    out_sat_r  <= sat_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_mesh_size      = out_size_r;
  assign out_size_saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/msf_checker.sv =====
`default_nettype none

module msf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [msf_pkg::SIZE_BITS-1:0] out_mesh_size,
  input logic                          out_size_saturated
);
  import msf_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted word produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without accepted word");

  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_size_saturated) |-> (out_mesh_size == '0) || (out_mesh_size == '1))
    else $error("saturated size not at a range limit");

endmodule

bind mesh_size_field_two_circles msf_checker u_msf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_mesh_size      (out_mesh_size),
  .out_size_saturated (out_size_saturated)
);

`default_nettype wire

// ===== tb/mesh_size_checker.sv =====
`timescale 1ns / 1ps

module mesh_size_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic               out_valid,
  input  logic [19:0]        out_mesh_size,
  input  logic               out_size_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_count,
  output int                 sat_count
);
  import msf_pkg::*;

  typedef struct packed {
    logic [19:0] size;
    logic        sat;
  } size_word_t;

  logic [19:0] base_q;
  logic [47:0] nctr_q, hctr_q;
  logic [59:0] nshape_q, hshape_q;
  size_word_t  size_queue[$];

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint floor_sh16(input longint v);
    if (v >= 0) return v >>> 16;
    return -(((-v) + 65535) >>> 16);
  endfunction

  function automatic longint floor_quot(input longint num, input longint den);
    if (num >= 0) return num / den;
    return -(((-num) + den - 1) / den);
  endfunction

  // Returns 1 and the proposed size when the point falls within the band.
  function automatic bit circle_blend(input longint px, input longint py,
                                      input logic [47:0] ctr, input logic [59:0] shp,
                                      output longint v);
    longint cx, cy, dx, dy, dist_v, d, t, t2, t3, p, rad, nr, band, far;
    cx = longint'($signed(ctr[23:0]));
    cy = longint'($signed(ctr[47:24]));
    rad = shp[19:0];
    nr = shp[39:20];
    band = shp[59:40];
    far = 64'sd1 << 21;
    dx = px - cx;
    dy = py - cy;
    v = 0;
    if (band == 0) return 0;
    if (dx >= far || dx <= -far || dy >= far || dy <= -far) return 0;
    dist_v = longint'(int_sqrt(longint'(dx * dx + dy * dy)));
    d = dist_v - rad;
    if (d >= band) return 0;
    t = floor_quot(d * 65536, band);
    if (t < -(64'sd128 << 16)) t = -(64'sd128 << 16);
    t2 = floor_sh16(t * t);
    t3 = floor_sh16(t2 * t);
    p = 3 * t2 - 2 * t3;
    v = nr + floor_sh16((longint'(base_q) - nr) * p);
    return 1;
  endfunction

  function automatic size_word_t predict_size(input longint px, input longint py);
    longint sz, v;
    size_word_t w;
    sz = base_q;
    if (circle_blend(px, py, nctr_q, nshape_q, v)) sz = v;
    if (circle_blend(px, py, hctr_q, hshape_q, v) && v < sz) sz = v;
    w.sat = 1'b0;
    if (sz < 0) begin
      sz = 0;
      w.sat = 1'b1;
    end else if (sz > 64'd1048575) begin
      sz = 1048575;
      w.sat = 1'b1;
    end
    w.size = sz[19:0];
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending_count = size_queue.size();

  always @(posedge clk) begin
    size_word_t w;
    if (!rst_n) begin
      fail_count = 0;
      sat_count = 0;
      base_q   <= BASE_RESET;
      nctr_q   <= '0;
      nshape_q <= '0;
      hctr_q   <= '0;
      hshape_q <= '0;
    end else begin
      if (out_valid) begin
        if (size_queue.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          w = size_queue.pop_front();
          if (out_mesh_size !== w.size)
            report_mismatch($sformatf("mesh_size %0h, want %0h", out_mesh_size, w.size));
          if (out_size_saturated !== w.sat)
            report_mismatch($sformatf("size_saturated %0b, want %0b",
                                      out_size_saturated, w.sat));
          if (w.sat) sat_count++;
        end
      end
      if (start && !busy)
        size_queue.push_back(predict_size(longint'(in_point_x), longint'(in_point_y)));
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_BASE:   base_q   <= pwdata[19:0];
          REG_NCTR:   nctr_q   <= pwdata[47:0];
          REG_NSHAPE: nshape_q <= pwdata[59:0];
          REG_HCTR:   hctr_q   <= pwdata[47:0];
          REG_HSHAPE: hshape_q <= pwdata[59:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/mesh_size_field_two_circles_tb.sv =====
`timescale 1ns / 1ps

module mesh_size_field_two_circles_tb;
  import msf_pkg::*;

  localparam int LIMIT = 400000;

  logic clk, rst_n, start, busy, out_valid, out_size_saturated;
  logic signed [23:0] in_point_x, in_point_y;
  logic [19:0] out_mesh_size;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;
  int fail_count, pending_count, sat_count, word_count;
  int cycles = 0;

  mesh_size_field_two_circles i_dut (
    .clk, .rst_n, .start, .busy, .in_point_x, .in_point_y,
    .out_valid, .out_mesh_size, .out_size_saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mesh_size_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_point_x, .in_point_y,
    .out_valid, .out_mesh_size, .out_size_saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending_count, .sat_count
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Hold off until the pipeline has drained.
  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic send_point(input logic [23:0] x, input logic [23:0] y, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    do @(posedge clk); while (busy);
    word_count++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic logic [23:0] near_coord(input logic [23:0] c, input int spread);
    return c + 24'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic random_config(input int mode);
    logic [19:0] rad, nr, band;
    logic [47:0] ctr;
    for (int c = 0; c < 2; c++) begin
      rad = (mode == 0) ? 20'hfffff : 20'($urandom_range(0, 20'h60000));
      nr = (mode == 1) ? 20'hfffff : 20'($urandom);
      band = (mode == 0) ? 20'hfffff : ($urandom_range(0, 7) == 0) ? 20'd0
                                      : 20'($urandom_range(1, 20'h40000));
      ctr = {24'($urandom), 24'($urandom)};
      if (mode == 2) ctr = '0;
      reg_write(c ? REG_HCTR : REG_NCTR, {16'd0, ctr});
      reg_write(c ? REG_HSHAPE : REG_NSHAPE, {4'd0, band, nr, rad});
    end
    reg_write(REG_BASE, (mode == 1) ? 64'd0 : (mode == 0) ? 64'hfffff : 64'($urandom));
  endtask

  initial begin
    logic [47:0] nctr, hctr;
    logic [23:0] bx, by;
    int sel;
    word_count = 0;
    start = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset values, extremes, disabled band, inside and far points.
    send_point(24'h000000, 24'h000000, 0);
    send_point(24'h7fffff, 24'h800000, 0);
    idle_input();
    drain();
    reg_write(REG_NCTR, {24'h010000, 24'hff0000});
    reg_write(REG_NSHAPE, {4'd0, 20'h20000, 20'h00800, 20'h10000});
    reg_write(REG_HCTR, {24'h000000, 24'h030000});
    reg_write(REG_HSHAPE, {4'd0, 20'h08000, 20'hfffff, 20'h08000});
    reg_write(REG_BASE, 64'h1999a);
    send_point(24'hff0000, 24'h010000, 0);
    send_point(24'hff8000, 24'h010000, 0);
    send_point(24'hfe0000, 24'h010000, 0);
    send_point(24'h030000, 24'h000000, 0);
    send_point(24'h034000, 24'h000000, 0);
    send_point(24'h7fffff, 24'h7fffff, 0);
    send_point(24'h800000, 24'h800000, 0);
    send_point(24'h200000, 24'h000000, 0);
    send_point(24'hffffff, 24'h000001, 0);
    idle_input();
    drain();
    // Tiny band with a point deep inside drives t to its clamp.
    reg_write(REG_NSHAPE, {4'd0, 20'h00001, 20'h00100, 20'hfffff});
    reg_write(REG_HSHAPE, {4'd0, 20'h00001, 20'h0ffff, 20'hfffff});
    send_point(24'hff0000, 24'h010000, 0);
    send_point(24'h030000, 24'h000000, 0);
    idle_input();
    drain();
    reg_write(REG_BASE, 64'h00100);
    send_point(24'hff0000, 24'h010000, 0);
    idle_input();
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      random_config(phase % 4);
      nctr = i_checker.nctr_q;
      hctr = i_checker.hctr_q;
      for (int k = 0; k < 50; k++) begin
        sel = $urandom_range(0, 9);
        bx = (sel < 5) ? nctr[23:0] : hctr[23:0];
        by = (sel < 5) ? nctr[47:24] : hctr[47:24];
        if (sel >= 8) begin
          bx = 24'($urandom);
          by = 24'($urandom);
        end else begin
          bx = near_coord(bx, 20'h50000);
          by = near_coord(by, 20'h50000);
        end
        send_point(bx, by, (phase % 3) != 2);
      end
      idle_input();
      drain();
    end

    $display("sent %0d points over 14 register settings, %0d saturated results",
             word_count, sat_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
